@@ hw/rtl/sdiv_pkg.sv @@
// Shared types and constants for the signed 32-bit pipelined divider.
`timescale 1ns / 1ps
`default_nettype none

package sdiv_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int BITS_PER_STAGE = 2;

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
  } sdiv_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         overflow;
    logic                         zero_divisor;
  } sdiv_out_t;

  // State of one item as it moves down the quotient pipeline
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;   // partial remainder, below den whenever den is nonzero
    logic [DATA_WIDTH-1:0] num;   // dividend magnitude bits still to consume, msb first
    logic [DATA_WIDTH-1:0] den;   // divisor magnitude
    logic [DATA_WIDTH-1:0] quo;   // quotient bits so far, shifted in at the lsb
    logic                  neg;   // result is negative
    logic                  ovf;
    logic                  zdiv;
  } sdiv_work_t;

endpackage

`default_nettype wire

@@ hw/rtl/sdiv_stage.sv @@
// One register stage of the divider: STEPS restoring shift-and-subtract steps.
`timescale 1ns / 1ps
`default_nettype none

module sdiv_stage
  import sdiv_pkg::*;
#(
  parameter int STEPS = BITS_PER_STAGE
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       prev_valid,
  input  wire sdiv_work_t prev_work,
  output logic            valid,
  output sdiv_work_t      work
);

  sdiv_work_t work_next;

  always_comb begin
    sdiv_work_t            w;
    logic [DATA_WIDTH:0]   partial;
    logic [DATA_WIDTH:0]   diff;
    logic                  qbit;
    w = prev_work;
    for (int s = 0; s < STEPS; s++) begin
      partial = {w.rem, w.num[DATA_WIDTH-1]};
      diff    = partial - {1'b0, w.den};
      qbit    = (partial >= {1'b0, w.den});
      w.rem   = qbit ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
      w.num   = {w.num[DATA_WIDTH-2:0], 1'b0};
      w.quo   = {w.quo[DATA_WIDTH-2:0], qbit};
    end
    work_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/signed_int32_divider.sv @@
// Top level of the pipelined signed 32-bit divider, quotient truncated toward zero.
//
// Channels: req (valid/ready, sdiv_in_t: numerator, denominator) and
// rsp (valid/ready, sdiv_out_t: quotient, overflow, zero_divisor).
// One result per request, in request order.
// Pipeline: one register that takes magnitudes and flags, DATA_WIDTH /
// STEPS_PER_STAGE quotient stages of STEPS_PER_STAGE restoring steps each,
// and an output register that applies the sign and saturation.
// Throughput: one item per cycle while rsp is not stalled; the depth of the
// step chain within a quotient stage sets the clock rate.
// Division by zero and -2^31 / -1 give 2^31-1 with zero_divisor or overflow.
// Reset (rst, synchronous) empties the pipeline; no item is in flight after it.
// While rsp_valid is high and rsp_ready low the whole pipeline holds and
// req_ready is low, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module signed_int32_divider
  import sdiv_pkg::*;
#(
  parameter int STEPS_PER_STAGE = BITS_PER_STAGE
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire sdiv_in_t  req_data,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output sdiv_out_t      rsp_data
);

  localparam int NUM_STAGES = DATA_WIDTH / STEPS_PER_STAGE;

  logic       advance;
  logic       stage_valid [NUM_STAGES+1];
  sdiv_work_t stage_work  [NUM_STAGES+1];
  logic       prep_valid;
  sdiv_work_t prep_work;
  sdiv_work_t prep_next;
  sdiv_out_t  rsp_next;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;

  // Operand preparation: signs, magnitudes, special cases
  always_comb begin
    logic nneg;
    logic dneg;
    nneg = req_data.numerator[DATA_WIDTH-1];
    dneg = req_data.denominator[DATA_WIDTH-1];
    prep_next.rem  = '0;
    prep_next.quo  = '0;
    // magnitude of -2^(n-1) is 2^(n-1), still fits unsigned
    prep_next.num  = nneg ? (~req_data.numerator + 1'b1) : req_data.numerator;
    prep_next.den  = dneg ? (~req_data.denominator + 1'b1) : req_data.denominator;
    prep_next.neg  = nneg ^ dneg;
    prep_next.zdiv = (req_data.denominator == '0);
    prep_next.ovf  = (req_data.numerator == MIN_NEG) && (req_data.denominator == MINUS_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (advance) begin
      prep_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prep_work <= prep_next;
    end
  end

  assign stage_valid[0] = prep_valid;
  assign stage_work[0]  = prep_work;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sdiv_stage #(
      .STEPS(STEPS_PER_STAGE)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (stage_valid[g]),
      .prev_work  (stage_work[g]),
      .valid      (stage_valid[g+1]),
      .work       (stage_work[g+1])
    );
  end

  // Sign fix-up and saturation
  always_comb begin
    sdiv_work_t w;
    w = stage_work[NUM_STAGES];
    rsp_next.overflow     = w.ovf && !w.zdiv;
    rsp_next.zero_divisor = w.zdiv;
    if (w.zdiv || w.ovf) begin
      rsp_next.quotient = MAX_POS;
    end else if (w.neg) begin
      rsp_next.quotient = ~w.quo + 1'b1;
    end else begin
      rsp_next.quotient = w.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.overflow && rsp_data.zero_divisor))
    else $error("overflow and zero_divisor raised together");

  a_saturated_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.overflow || rsp_data.zero_divisor)
      |-> rsp_data.quotient == MAX_POS)
    else $error("flagged result not saturated");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while output stalled");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(stage_valid[NUM_STAGES]))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
